>>> rtl/core/acf_pkg.sv
package acf_pkg;

	localparam int MAX_TAPS_DEF    = 32;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int OUT_W           = 37;
	localparam int TAP_INDEX_W     = 5;
	localparam int TAP_COUNT_W     = 6;

	typedef enum logic {
		OP_LOAD   = 1'b0,
		OP_SAMPLE = 1'b1
	} op_t;

	typedef enum logic {
		ST_IDLE,
		ST_BUSY
	} acf_state_t;

	// control fanned out to every cell
	typedef struct packed {
		logic                   shift;
		logic                   clear;
		logic                   load;
		logic [TAP_INDEX_W-1:0] index;
	} acf_ctl_t;

endpackage

>>> rtl/core/audio_convolution_fir.sv
// Direct-form FIR filter, linear convolution of an audio stream with a
// loaded impulse response.
// Input channel (in_valid/in_ready): operation 0 loads sample_value as the
// coefficient at tap_index (ignored at or above MAX_TAPS), operation 1 pushes
// one sample. A sample with last_sample set also flushes m-1 tail outputs, with
// m the taps in use (tap_count held to 1..MAX_TAPS), and then clears the
// history; the final output has last_output set.
// Output channel (out_valid/out_ready): one filtered_value per output index,
// the exact Q7.30 sum of products, wrapping at 37 bits.
// The partial sum walks the row of cells one tap per clock behind a
// registered product in each cell. The next transaction is taken in the
// cycle after the last result for a sample is captured into the output
// register, so no new sample is taken while one is still in flight.
// Results sit in an output register; if the receiver stalls, the next result
// waits in the cell row until the register frees up.
// Reset clears coefficients and history to zero and sets tap_count to 1.
// cfg_we writes tap_count from cfg_data; write it only while the block idles.
module audio_convolution_fir import acf_pkg::*; #(
	parameter int MAX_TAPS    = MAX_TAPS_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [TAP_COUNT_W-1:0]        cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          operation,
	input  logic [TAP_INDEX_W-1:0]        tap_index,
	input  logic signed [SAMPLE_BITS-1:0] sample_value,
	input  logic                          last_sample,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [OUT_W-1:0]       filtered_value,
	output logic                          last_output
);

	localparam int M_W = $clog2(MAX_TAPS + 1);

	acf_ctl_t                      ctl;
	logic signed [SAMPLE_BITS-1:0] shift_value;
	logic [M_W-1:0]                tap_m;
	logic [MAX_TAPS-1:0]           tap_en;
	logic signed [SAMPLE_BITS-1:0] samp_chain [MAX_TAPS];
	logic [OUT_W-1:0]              sum_chain [MAX_TAPS];

	acf_ctrl #(
		.MAX_TAPS    (MAX_TAPS),
		.SAMPLE_BITS (SAMPLE_BITS),
		.M_W         (M_W)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.operation      (operation),
		.tap_index      (tap_index),
		.sample_value   (sample_value),
		.last_sample    (last_sample),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.filtered_value (filtered_value),
		.last_output    (last_output),
		.ctl            (ctl),
		.shift_value    (shift_value),
		.tap_m          (tap_m),
		.chain_sum      (sum_chain[MAX_TAPS-1])
	);

	for (genvar g = 0; g < MAX_TAPS; g++) begin : g_cell
		assign tap_en[g] = (M_W'(g) < tap_m);

		acf_cell #(
			.SAMPLE_BITS (SAMPLE_BITS),
			.INDEX       (g)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.tap_en     (tap_en[g]),
			.coef_in    (sample_value),
			.sample_in  ((g == 0) ? shift_value : samp_chain[(g == 0) ? 0 : g - 1]),
			.sample_out (samp_chain[g]),
			.sum_in     ((g == 0) ? {OUT_W{1'b0}} : sum_chain[(g == 0) ? 0 : g - 1]),
			.sum_out    (sum_chain[g])
		);
	end

endmodule

>>> rtl/core/acf_cell.sv
module acf_cell import acf_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int INDEX       = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  acf_ctl_t                      ctl,
	input  logic                          tap_en,
	input  logic signed [SAMPLE_BITS-1:0] coef_in,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	output logic signed [SAMPLE_BITS-1:0] sample_out,
	input  logic        [OUT_W-1:0]       sum_in,
	output logic        [OUT_W-1:0]       sum_out
);

	localparam int PW = 2 * SAMPLE_BITS;
	localparam int EW = (PW > OUT_W) ? PW : OUT_W;

	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic signed [SAMPLE_BITS-1:0] coef_q;
	logic signed [PW-1:0]          prod_s1;
	logic signed [EW-1:0]          prod_ext;
	logic        [OUT_W-1:0]       sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_q <= '0;
			coef_q   <= '0;
		end else begin
			if (ctl.clear) begin
				sample_q <= '0;
			end else if (ctl.shift) begin
				sample_q <= sample_in;
			end
			if (ctl.load && (int'(ctl.index) == INDEX)) begin
				coef_q <= coef_in;
			end
		end
	end

	assign prod_ext = EW'(prod_s1);

	always_ff @(posedge clk) begin
		prod_s1 <= sample_q * coef_q;
		sum_q   <= sum_in + (tap_en ? prod_ext[OUT_W-1:0] : {OUT_W{1'b0}});
	end

	assign sample_out = sample_q;
	assign sum_out    = sum_q;

endmodule

>>> rtl/core/acf_ctrl.sv
module acf_ctrl import acf_pkg::*; #(
	parameter int MAX_TAPS    = MAX_TAPS_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int M_W         = $clog2(MAX_TAPS + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [TAP_COUNT_W-1:0]        cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          operation,
	input  logic [TAP_INDEX_W-1:0]        tap_index,
	input  logic signed [SAMPLE_BITS-1:0] sample_value,
	input  logic                          last_sample,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [OUT_W-1:0]       filtered_value,
	output logic                          last_output,
	output acf_ctl_t                      ctl,
	output logic signed [SAMPLE_BITS-1:0] shift_value,
	output logic [M_W-1:0]                tap_m,
	input  logic [OUT_W-1:0]              chain_sum
);

	localparam int             C_W = $clog2(MAX_TAPS + 2);
	localparam logic [C_W-1:0] CAP = C_W'(MAX_TAPS + 1);

	acf_state_t             state_q, state_d;
	logic [TAP_COUNT_W-1:0] tap_count_q;
	logic [C_W-1:0]         cnt_q;
	logic [M_W-1:0]         tail_q;
	logic                   sig_last_q;
	logic                   out_valid_q;
	logic signed [OUT_W-1:0] filt_q;
	logic                   out_last_q;
	logic                   accept;
	logic                   take_sample;
	logic                   capture;

	always_comb begin
		if (tap_count_q == '0) begin
			tap_m = M_W'(1);
		end else if (int'(tap_count_q) > MAX_TAPS) begin
			tap_m = M_W'(MAX_TAPS);
		end else begin
			tap_m = M_W'(tap_count_q);
		end
	end

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		capture     = 1'b0;
		ctl         = '0;
		ctl.index   = tap_index;
		shift_value = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				shift_value = sample_value;
				if (in_valid) begin
					if (op_t'(operation) == OP_SAMPLE) begin
						ctl.shift = 1'b1;
						state_d   = ST_BUSY;
					end else begin
						ctl.load = 1'b1;
					end
				end
			end
			ST_BUSY: begin
				if ((cnt_q == CAP) && (!out_valid_q || out_ready)) begin
					capture = 1'b1;
					if (tail_q != '0) begin
						ctl.shift = 1'b1;
					end else begin
						ctl.clear = sig_last_q;
						state_d   = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign accept      = in_valid && in_ready;
	assign take_sample = accept && (op_t'(operation) == OP_SAMPLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= TAP_COUNT_W'(1);
			cnt_q       <= '0;
			tail_q      <= '0;
			sig_last_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				tap_count_q <= cfg_data;
			end
			if (take_sample) begin
				cnt_q      <= '0;
				tail_q     <= last_sample ? (tap_m - M_W'(1)) : '0;
				sig_last_q <= last_sample;
			end else if (capture) begin
				cnt_q <= '0;
				if (tail_q != '0) begin
					tail_q <= tail_q - M_W'(1);
				end
			end else if ((state_q == ST_BUSY) && (cnt_q != CAP)) begin
				cnt_q <= cnt_q + C_W'(1);
			end
			if (capture) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			filt_q     <= chain_sum;
			out_last_q <= sig_last_q && (tail_q == '0);
		end
	end

	assign out_valid      = out_valid_q;
	assign filtered_value = filt_q;
	assign last_output    = out_last_q;

	a_tail_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BUSY) |-> (tail_q < tap_m))
		else $error("tail count beyond tap count");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CAP)
		else $error("settle counter overran");

	a_busy_shift: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_BUSY) && ctl.shift) |-> (cnt_q == CAP))
		else $error("history moved before the sum settled");

	a_clear_alone: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.clear && (ctl.shift || ctl.load)))
		else $error("history clear overlaps a shift or load");

	a_capture_loads: assert property (@(posedge clk) disable iff (!arst_n)
		capture |=> out_valid_q)
		else $error("captured result not presented");

endmodule
